// ----- design/anp_pkg.sv -----
// ============================================================================
// anp_pkg: shared types and constants of the ASCII number parser
// Holds the character codes, radix constants, the classified-byte record
// passed from the front end to the back end, and the parse phase encoding.
// ============================================================================
`default_nettype none

package anp_pkg;

    // Character codes the parser reacts to.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_B  = 8'h42;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_B  = 8'h62;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

    // Radix values.
    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_BIN   = 6'd2;
    localparam logic [5:0] RADIX_OCT   = 6'd8;
    localparam logic [5:0] RADIX_DEC   = 6'd10;
    localparam logic [5:0] RADIX_HEX   = 6'd16;
    localparam logic [5:0] LETTER_BASE = 6'd10;

    // Register index of the radix register.
    localparam logic REG_NUMBER_BASE = 1'b0;

    // One input byte after classification.
    typedef struct packed {
        logic       digit_ok;   // byte is 0-9, a-z or A-Z
        logic [5:0] digit;      // digit value 0..35
        logic       blank;      // space or tab
        logic       minus;      // '-'
        logic       zero;       // '0'
        logic       hex_x;      // 'x' or 'X'
        logic       bin_b;      // 'b' or 'B'
        logic       nul;        // end of string
    } t_cls;

    // Parse phases, one-hot.
    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_PREFIX = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

// ----- design/ascii_number_parser.sv -----
// ============================================================================
// ascii_number_parser: streaming ASCII-to-integer converter
// Parses NUL-terminated strings to 64-bit values, at most one byte per cycle.
// ============================================================================
// Usage:
// Bytes enter on push/full: a request is taken at a clock edge with push high
// and full low. Parsed values leave on empty/pop: the oldest value sits on
// o_parsed_value while empty is low and is taken at an edge with pop high.
// Each string yields at most one value, issued by the first byte that ends
// the number (or by the terminating NUL if the number runs to the end).
// The radix register at address 0 (6 bits, reset 10, 0 = auto-detect from
// a 0x, 0b or 0 prefix) is sampled at the first non-blank byte of a string.
// The byte that ends the number passes the byte queue and the back end; the
// value is then registered in the result queue. Throughput is one byte per
// cycle if the result queue has room, set by the accumulator multiply-add.
// A two-entry byte queue feeds the back end and a two-entry result queue
// follows it; when the receiver stops popping, the result queue fills, the
// back end stalls, and full rises once the byte queue is full as well.
// Reset (synchronous, active low) empties both queues, returns the parser
// to the blank-skipping phase and sets the radix register to 10.
// ============================================================================
`default_nettype none

module ascii_number_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Byte channel
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_text_byte,
    // Result channel
    output logic        empty,
    input  wire         pop,
    output logic [63:0] o_parsed_value,
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]    r_number_base;
    logic          w_cls_valid;
    anp_pkg::t_cls w_cls;
    logic          w_cls_pop;
    logic          w_res_push;
    logic [63:0]   w_res_value;
    logic          w_res_full;
    logic          w_sel_base;

    // Register decode and read-back.
    assign pready     = 1'b1;
    assign w_sel_base = (paddr[2] == anp_pkg::REG_NUMBER_BASE);
    assign prdata     = w_sel_base ? {26'd0, r_number_base} : 32'd0;

    // Radix register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= anp_pkg::RADIX_DEC;
        end else if (psel && penable && pwrite && pready && w_sel_base) begin
            r_number_base <= pwdata[5:0];
        end
    end

    // Front end: intake and classification.
    anp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_text_byte (i_text_byte),
        .o_cls_valid (w_cls_valid),
        .o_cls       (w_cls),
        .i_cls_pop   (w_cls_pop)
    );

    // Back end: parsing and accumulation.
    anp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_number_base (r_number_base),
        .i_cls_valid   (w_cls_valid),
        .i_cls         (w_cls),
        .o_cls_pop     (w_cls_pop),
        .o_res_push    (w_res_push),
        .o_res_value   (w_res_value),
        .i_res_full    (w_res_full)
    );

    // Result queue.
    anp_out_queue u_out_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (w_res_push),
        .i_value        (w_res_value),
        .o_full         (w_res_full),
        .empty          (empty),
        .pop            (pop),
        .o_parsed_value (o_parsed_value)
    );

endmodule

`default_nettype wire

// ----- design/anp_front.sv -----
// ============================================================================
// anp_front: byte intake and classification
// Classifies each accepted byte and holds it in a two-entry queue until the
// back end takes it.
// ============================================================================
`default_nettype none

module anp_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             push,
    output logic            full,
    input  wire  [7:0]      i_text_byte,
    output logic            o_cls_valid,
    output anp_pkg::t_cls   o_cls,
    input  wire             i_cls_pop
);

    anp_pkg::t_cls r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    anp_pkg::t_cls w_cls;
    logic          w_wr;
    logic          w_rd;
    logic          w_is_num;
    logic          w_is_lo;
    logic          w_is_up;

    // Character classification.
    always_comb begin
        w_is_num = (i_text_byte >= anp_pkg::CHAR_ZERO) && (i_text_byte <= anp_pkg::CHAR_NINE);
        w_is_lo  = (i_text_byte >= anp_pkg::CHAR_LO_A) && (i_text_byte <= anp_pkg::CHAR_LO_Z);
        w_is_up  = (i_text_byte >= anp_pkg::CHAR_UP_A) && (i_text_byte <= anp_pkg::CHAR_UP_Z);
        w_cls.digit_ok = w_is_num || w_is_lo || w_is_up;
        if (w_is_num) begin
            w_cls.digit = 6'(i_text_byte - anp_pkg::CHAR_ZERO);
        end else if (w_is_lo) begin
            w_cls.digit = 6'(i_text_byte - anp_pkg::CHAR_LO_A) + anp_pkg::LETTER_BASE;
        end else begin
            w_cls.digit = 6'(i_text_byte - anp_pkg::CHAR_UP_A) + anp_pkg::LETTER_BASE;
        end
        w_cls.blank = (i_text_byte == anp_pkg::CHAR_SPACE) || (i_text_byte == anp_pkg::CHAR_TAB);
        w_cls.minus = (i_text_byte == anp_pkg::CHAR_MINUS);
        w_cls.zero  = (i_text_byte == anp_pkg::CHAR_ZERO);
        w_cls.hex_x = (i_text_byte == anp_pkg::CHAR_LO_X) || (i_text_byte == anp_pkg::CHAR_UP_X);
        w_cls.bin_b = (i_text_byte == anp_pkg::CHAR_LO_B) || (i_text_byte == anp_pkg::CHAR_UP_B);
        w_cls.nul   = (i_text_byte == anp_pkg::CHAR_NUL);
    end

    // Queue handshakes.
    assign full        = (r_count == 2'd2);
    assign o_cls_valid = (r_count != 2'd0);
    assign o_cls       = r_mem[r_rd_ptr];
    assign w_wr        = push && !full;
    assign w_rd        = i_cls_pop && o_cls_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/anp_back.sv -----
// ============================================================================
// anp_back: parse state machine and accumulator
// Takes at most one classified byte per cycle, tracks blanks, signs and
// prefix, accumulates digits, and issues finished values to the result queue.
// ============================================================================
`default_nettype none

module anp_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire  [5:0]      i_number_base,
    input  wire             i_cls_valid,
    input  anp_pkg::t_cls   i_cls,
    output logic            o_cls_pop,
    output logic            o_res_push,
    output logic [63:0]     o_res_value,
    input  wire             i_res_full
);

    anp_pkg::t_phase r_phase;
    anp_pkg::t_phase n_phase;
    logic            r_neg;
    logic            n_neg;
    logic [5:0]      r_radix;
    logic [5:0]      n_radix;
    logic [63:0]     r_acc;
    logic [63:0]     n_acc;
    logic            w_adv;
    logic [5:0]      w_radix;
    logic            w_take;
    logic            w_num;
    logic            w_emit;
    logic [63:0]     w_prod;

    // A byte moves only when the result queue has room.
    assign w_adv     = i_cls_valid && !i_res_full;
    assign o_cls_pop = w_adv;

    // Radix that applies to this byte.
    always_comb begin
        unique case (r_phase)
            anp_pkg::PH_SIGN:   w_radix = r_radix;
            anp_pkg::PH_PREFIX: w_radix = anp_pkg::RADIX_OCT;
            anp_pkg::PH_DIGITS: w_radix = r_radix;
            anp_pkg::PH_DONE:   w_radix = r_radix;
            default:            w_radix = i_number_base;
        endcase
    end

    // One multiply-add per digit.
    assign w_take = i_cls.digit_ok && (i_cls.digit < w_radix);
    assign w_prod = r_acc * {58'd0, w_radix};

    // Next-state logic.
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_radix = r_radix;
        n_acc   = r_acc;
        w_num   = 1'b0;
        w_emit  = 1'b0;
        unique case (r_phase)
            anp_pkg::PH_SIGN: begin
                if (i_cls.minus) begin
                    n_neg = ~r_neg;
                end else if ((w_radix == anp_pkg::RADIX_AUTO) && i_cls.zero) begin
                    n_phase = anp_pkg::PH_PREFIX;
                end else begin
                    w_num = 1'b1;
                end
            end
            anp_pkg::PH_PREFIX: begin
                if (i_cls.hex_x) begin
                    n_radix = anp_pkg::RADIX_HEX;
                    n_phase = anp_pkg::PH_DIGITS;
                end else if (i_cls.bin_b) begin
                    n_radix = anp_pkg::RADIX_BIN;
                    n_phase = anp_pkg::PH_DIGITS;
                end else begin
                    n_radix = anp_pkg::RADIX_OCT;
                    w_num   = 1'b1;
                end
            end
            anp_pkg::PH_DIGITS: begin
                w_num = 1'b1;
            end
            anp_pkg::PH_DONE: begin
                if (i_cls.nul) begin
                    n_phase = anp_pkg::PH_SKIP;
                    n_neg   = 1'b0;
                    n_acc   = 64'd0;
                    n_radix = i_number_base;
                end
            end
            default: begin
                // Skip blanks; the first other byte latches the radix.
                n_phase = anp_pkg::PH_SKIP;
                if (!i_cls.blank) begin
                    n_radix = i_number_base;
                    if (i_cls.minus) begin
                        n_neg   = ~r_neg;
                        n_phase = anp_pkg::PH_SIGN;
                    end else if ((w_radix == anp_pkg::RADIX_AUTO) && i_cls.zero) begin
                        n_phase = anp_pkg::PH_PREFIX;
                    end else begin
                        w_num = 1'b1;
                    end
                end
            end
        endcase

        // Digit accumulation or end of the number.
        if (w_num) begin
            if (w_take) begin
                n_acc   = w_prod + {58'd0, i_cls.digit};
                n_phase = anp_pkg::PH_DIGITS;
            end else begin
                w_emit = 1'b1;
                if (i_cls.nul) begin
                    n_phase = anp_pkg::PH_SKIP;
                    n_neg   = 1'b0;
                    n_acc   = 64'd0;
                    n_radix = i_number_base;
                end else begin
                    n_phase = anp_pkg::PH_DONE;
                end
            end
        end
    end

    // Result toward the output queue.
    assign o_res_push  = w_adv && w_emit;
    assign o_res_value = r_neg ? (64'd0 - r_acc) : r_acc;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= anp_pkg::PH_SKIP;
            r_neg   <= 1'b0;
            r_radix <= anp_pkg::RADIX_DEC;
            r_acc   <= 64'd0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_radix <= n_radix;
            r_acc   <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ----- design/anp_out_queue.sv -----
// ============================================================================
// anp_out_queue: result queue
// Two-entry queue of parsed values between the back end and the result port.
// ============================================================================
`default_nettype none

module anp_out_queue (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire  [63:0] i_value,
    output logic        o_full,
    output logic        empty,
    input  wire         pop,
    output logic [63:0] o_parsed_value
);

    logic [63:0] r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_wr;
    logic        w_rd;

    // Handshakes.
    assign o_full         = (r_count == 2'd2);
    assign empty          = (r_count == 2'd0);
    assign o_parsed_value = r_mem[r_rd_ptr];
    assign w_wr           = i_push && !o_full;
    assign w_rd           = pop && !empty;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_value;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire
